@@ rtl/modular_exponentiation_macros.svh @@
// assertion macros shared by the modular exponentiation checkers
// no dependencies; included by the checker file
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, disabled during reset
`define MODEXP_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("modexp check failed");

// next-cycle implication, disabled during reset
`define MODEXP_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("modexp check failed");

`endif

@@ rtl/modexp_pkg.sv @@
// shared widths, reset constants and unit command/status types
// for the modular exponentiation block; no dependencies
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int MOD_W            = 31;
   localparam int BASE_W           = 32;
   localparam int EXP_W            = 63;
   localparam int EXP_BITS_DEFAULT = 63;
   localparam int STEP_CNT_W       = 5;

   localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

   typedef struct packed {
      logic              start;
      logic              wide;     // scan all 32 multiplier bits, else the low 31
      logic [MOD_W-1:0]  modulus;
      logic [MOD_W-1:0]  mult_a;
      logic [BASE_W-1:0] mult_b;
   } mm_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] result;
   } mm_sts_type;

endpackage

@@ rtl/modexp_mulmod.sv @@
// shift-and-add modular multiplier, one multiplier bit per cycle
// depends on modexp_pkg
`timescale 1ns / 1ps

module modexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::mm_cmd_type cmd,
   output modexp_pkg::mm_sts_type sts
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [modexp_pkg::STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [modexp_pkg::MOD_W-1:0]        a_ff, a_in;
   logic [modexp_pkg::BASE_W-1:0]       b_ff, b_in;
   logic [modexp_pkg::MOD_W-1:0]        r_ff, r_in;

   logic [modexp_pkg::MOD_W:0]          mod_x;
   logic [modexp_pkg::MOD_W:0]          dbl;
   logic [modexp_pkg::MOD_W:0]          dbl_red;
   logic [modexp_pkg::MOD_W:0]          sum;
   logic [modexp_pkg::MOD_W:0]          sum_red;

   // r = (2r + bit * a) mod m, both partial values stay below 2m
   always_comb begin
      mod_x   = {1'b0, cmd.modulus};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_x) ? (dbl - mod_x) : dbl;
      sum     = dbl_red + (b_ff[modexp_pkg::BASE_W-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= mod_x) ? (sum - mod_x) : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         a_in    = cmd.mult_a;
         r_in    = '0;
         if (cmd.wide) begin
            b_in   = cmd.mult_b;
            cnt_in = modexp_pkg::STEP_CNT_W'(modexp_pkg::BASE_W - 1);
         end else begin
            b_in   = {cmd.mult_b[modexp_pkg::BASE_W-2:0], 1'b0};
            cnt_in = modexp_pkg::STEP_CNT_W'(modexp_pkg::MOD_W - 1);
         end
      end else if (busy_ff) begin
         r_in = sum_red[modexp_pkg::MOD_W-1:0];
         b_in = {b_ff[modexp_pkg::BASE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = r_ff;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Computes base^exponent mod modulus by right-to-left square and multiply. One item is
// in flight at a time: req_stall stays high from acceptance until the result has been
// loaded into the output register, which may still be waiting on rsp_stall when the
// next item is taken. All arithmetic runs on one shift-and-add modular multiplier that
// retires one multiplier bit per cycle; the base reduction scans all 32 base bits and
// each multiply or square the low 31 multiplier bits. After the reduction an item takes
// one multiply per set exponent bit and one square per position below its highest set
// bit. A modulus of zero acts as a modulus of one; a zero exponent gives 1 for any
// modulus. The modulus may only be written while idle.
// depends on modexp_pkg and modexp_mulmod
`timescale 1ns / 1ps

module modular_exponentiation #(
   parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [modexp_pkg::BASE_W-1:0] req_base,
   input  logic [modexp_pkg::EXP_W-1:0]  req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [modexp_pkg::MOD_W-1:0]  rsp_power,
   input  logic                          csr_wr_en,
   input  logic [modexp_pkg::MOD_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED,
      ST_MUL,
      ST_SQR,
      ST_FIN
   } state_type;

   state_type                    state_ff, state_in;
   logic [modexp_pkg::MOD_W-1:0] mod_ff, mod_in;
   logic [EXP_BITS-1:0]          e_ff, e_in;
   logic [modexp_pkg::MOD_W-1:0] acc_ff, acc_in;
   logic [modexp_pkg::MOD_W-1:0] sq_ff, sq_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [modexp_pkg::MOD_W-1:0] power_ff, power_in;

   logic [modexp_pkg::MOD_W-1:0] mod_eff;
   logic [EXP_BITS-1:0]          e_rest;
   modexp_pkg::mm_cmd_type       mm_cmd;
   modexp_pkg::mm_sts_type       mm_sts;

   modexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .cmd   (mm_cmd),
      .sts   (mm_sts)
   );

   assign mod_eff = (mod_ff == '0) ? modexp_pkg::MOD_W'(1) : mod_ff;
   assign e_rest  = e_ff >> 1;
   assign mod_in  = csr_wr_en ? csr_wr_data : mod_ff;

   always_comb begin
      state_in       = state_ff;
      e_in           = e_ff;
      acc_in         = acc_ff;
      sq_in          = sq_ff;
      power_in       = power_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      mm_cmd         = '0;
      mm_cmd.modulus = mod_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               e_in          = req_exponent[EXP_BITS-1:0];
               acc_in        = modexp_pkg::MOD_W'(1);
               // base mod m as 1 * base through the multiplier
               mm_cmd.start  = 1'b1;
               mm_cmd.wide   = 1'b1;
               mm_cmd.mult_a = modexp_pkg::MOD_W'(1);
               mm_cmd.mult_b = req_base;
               state_in      = ST_RED;
            end
         end
         ST_RED: begin
            if (mm_sts.done) begin
               sq_in = mm_sts.result;
               if (e_ff == '0) begin
                  state_in = ST_FIN;
               end else if (e_ff[0]) begin
                  mm_cmd.start  = 1'b1;
                  mm_cmd.mult_a = mm_sts.result;
                  mm_cmd.mult_b = {1'b0, acc_ff};
                  state_in      = ST_MUL;
               end else begin
                  mm_cmd.start  = 1'b1;
                  mm_cmd.mult_a = mm_sts.result;
                  mm_cmd.mult_b = {1'b0, mm_sts.result};
                  state_in      = ST_SQR;
               end
            end
         end
         ST_MUL: begin
            if (mm_sts.done) begin
               acc_in = mm_sts.result;
               // no higher exponent bits left: the square is not needed
               if (e_rest == '0) begin
                  state_in = ST_FIN;
               end else begin
                  mm_cmd.start  = 1'b1;
                  mm_cmd.mult_a = sq_ff;
                  mm_cmd.mult_b = {1'b0, sq_ff};
                  state_in      = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mm_sts.done) begin
               sq_in = mm_sts.result;
               e_in  = e_rest;
               mm_cmd.start  = 1'b1;
               mm_cmd.mult_a = mm_sts.result;
               if (e_rest[0]) begin
                  mm_cmd.mult_b = {1'b0, acc_ff};
                  state_in      = ST_MUL;
               end else begin
                  mm_cmd.mult_b = {1'b0, mm_sts.result};
                  state_in      = ST_SQR;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      power_ff <= power_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= modexp_pkg::MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_ff       <= mod_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = power_ff;

endmodule

@@ rtl/modexp_checker.sv @@
// port-level checks for modular_exponentiation, bound to the top level
// depends on modexp_pkg and modular_exponentiation_macros.svh
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"

module modexp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [modexp_pkg::MOD_W-1:0]  rsp_power,
   input logic                          csr_wr_en,
   input logic [modexp_pkg::MOD_W-1:0]  csr_wr_data
);

   logic [modexp_pkg::MOD_W-1:0] mod_ff;
   logic [1:0]                   pending_ff;
   logic [modexp_pkg::MOD_W-1:0] mod_eff;
   logic                         req_take;
   logic                         rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign mod_eff  = (mod_ff == '0) ? modexp_pkg::MOD_W'(1) : mod_ff;

   // mirror of the modulus and count of items accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff     <= modexp_pkg::MODULUS_RESET;
         pending_ff <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            mod_ff <= csr_wr_data;
         end
         pending_ff <= pending_ff + {1'b0, req_take} - {1'b0, rsp_take};
      end
   end

   `MODEXP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_power))
   `MODEXP_ASSERT_IMPLY(a_rsp_range, clock, reset, rsp_valid, (rsp_power < mod_eff) || (rsp_power == 1))
   `MODEXP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall)
   `MODEXP_ASSERT_IMPLY(a_rsp_from_item, clock, reset, rsp_valid, pending_ff != 2'd0)
   `MODEXP_ASSERT_IMPLY(a_pending_bound, clock, reset, 1'b1, pending_ff != 2'd3)

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_power   (rsp_power),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
